/* hdl/fuzzy_pd_steering_unit_defines.svh */
// Assertion macros for the fuzzy PD steering unit checker.
// No dependencies.
`ifndef FUZZY_PD_STEERING_UNIT_DEFINES_SVH
`define FUZZY_PD_STEERING_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define FPDS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fpds check failed");

// Next-cycle implication, disabled during reset.
`define FPDS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fpds check failed");

// Next-cycle implication, always active.
`define FPDS_ASSERT_NXT_ALL(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("fpds check failed");

`endif

/* hdl/fpds_pkg.sv */
// Shared types and constants of the fuzzy PD steering unit.
// No dependencies.
package fpds_pkg;

  localparam int DIV_W  = 29;
  localparam int DSR_W  = 16;
  localparam int CNT_W  = 5;

  localparam logic [16:0] ONE_MU = 17'd65536;
  localparam logic signed [23:0] RATE_MAX = 24'sd8388607;
  localparam logic signed [23:0] RATE_MIN = -24'sd8388608;

  localparam logic [2:0] CFG_ERR_P  = 3'd0;
  localparam logic [2:0] CFG_RATE_P = 3'd1;
  localparam logic [2:0] CFG_OUT_P  = 3'd2;
  localparam logic [2:0] CFG_ERR_D  = 3'd3;
  localparam logic [2:0] CFG_RATE_D = 3'd4;
  localparam logic [2:0] CFG_OUT_D  = 3'd5;
  localparam logic [2:0] CFG_TRIM   = 3'd6;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RATE,
    ST_RWAIT,
    ST_MSEL,
    ST_MWAIT,
    ST_MULA,
    ST_MULB,
    ST_SRVA,
    ST_SRVB,
    ST_SRVC,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic [8:0] pick9(input logic [62:0] w, input logic [2:0] i);
    return w[9*i +: 9];
  endfunction

endpackage

/* hdl/fuzzy_pd_steering_unit.sv */
// Fuzzy-gain PD steering unit: top level, sequencer and datapath.
// Depends on fpds_pkg and fpds_div.
//
// Input channel (in_valid/in_ready) takes one transaction per camera frame:
// a track center column and the frame period. Result channel
// (out_valid/out_ready) returns one transaction per input: servo value,
// slew-limited error and the two fuzzy gains.
// Configuration writes (cfg_wr_en, cfg_index, cfg_data) take effect at once
// and must only be issued while the unit is idle.
// After acceptance the unit runs setup, the 29-step rate division (skipped at
// zero period), one division per membership (4 of them; the division is
// skipped at or beyond the outer breakpoints), the gains on the shared
// multiplier, then the servo sum and output. The single shared divider is
// used in turn by the rate and every membership. in_ready is high only
// when idle, the cycle after the result is loaded, so a new transaction is
// not accepted until the last one has been loaded into the output register.
// A finished result waits in the output register while out_ready is low;
// the sequencer holds the next result until the waiting one is taken, then returns to idle.
// Synchronous reset clears the configuration, the stored last error and
// the handshake state.
module fuzzy_pd_steering_unit import fpds_pkg::*; #(
  parameter int IMAGE_COLUMNS = 320,
  parameter int SERVO_MID     = 1500
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [8:0]        in_center_column,
  input  logic [15:0]       in_frame_period,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [15:0]       out_servo_pwm,
  output logic signed [8:0] out_used_error,
  output logic [15:0]       out_prop_gain,
  output logic [15:0]       out_deriv_gain,
  input  logic              cfg_wr_en,
  input  logic [2:0]        cfg_index,
  input  logic [62:0]       cfg_data
);

  localparam int HALF = IMAGE_COLUMNS / 2;
  localparam int STEP = IMAGE_COLUMNS / 10;
  localparam int TW   = 44;
  localparam logic signed [11:0] HALF_S = 12'(HALF);
  localparam logic signed [11:0] STEP_S = 12'(STEP);

  state_t state_r, state_nxt;

  logic [62:0]        err_p_r, rate_p_r, out_p_r, err_d_r, rate_d_r, out_d_r;
  logic signed [9:0]  trim_r;
  logic signed [9:0]  last_r;

  logic signed [11:0] err_r, delta_r;
  logic [15:0]        period_r;
  logic signed [23:0] rate_r;
  logic [1:0]         m_r;
  logic [16:0]        mu_r [4];
  logic [2:0]         seg_r [4];
  logic [2:0]         term_r;
  logic [41:0]        acc_r;
  logic [15:0]        kp_r, kd_r;
  logic signed [58:0] prod_r;
  logic signed [TW-1:0] tot_r;
  logic [15:0]        servo_r;

  logic               out_valid_r;
  logic [15:0]        out_servo_r, out_kp_r, out_kd_r;
  logic signed [8:0]  out_err_r;

  div_req_t           div_req;
  div_stat_t          div_stat;
  logic [DIV_W-1:0]   div_quo;

  logic signed [33:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [58:0] mul_p;

  // accept-time error and slew limit
  logic signed [11:0] last_ext, err0, d0, err_n;
  always_comb begin
    last_ext = {{2{last_r[9]}}, last_r};
    err0     = signed'(12'(in_center_column)) - HALF_S;
    d0       = err0 - last_ext;
    if (d0 > STEP_S) begin
      err_n = last_ext + STEP_S;
    end else if (d0 < -STEP_S) begin
      err_n = last_ext - STEP_S;
    end else begin
      err_n = err0;
    end
  end

  // rate division operands and saturation
  logic [6:0]  abs_delta;
  logic [11:0] abs35;
  logic [23:0] q_sat;
  logic signed [24:0] rate_div;
  always_comb begin
    abs_delta = delta_r[11] ? 7'(-delta_r) : 7'(delta_r);
    abs35     = 12'(abs_delta) * 12'd35;
    q_sat     = (div_quo > DIV_W'(24'h800000)) ? 24'h800000 : div_quo[23:0];
    if (delta_r[11]) begin
      rate_div = -signed'({1'b0, q_sat});
    end else if (q_sat == 24'h800000) begin
      rate_div = 25'(RATE_MAX);
    end else begin
      rate_div = signed'({1'b0, q_sat});
    end
  end

  // fuzzification of the current membership m_r
  logic [62:0]        pw;
  logic signed [24:0] px [7];
  logic signed [24:0] fx, pk, pk1, num, den;
  logic [8:0]         raw;
  logic [2:0]         kk;
  logic               lo_edge, hi_edge;
  always_comb begin
    unique case (m_r)
      2'd0: pw = err_p_r;
      2'd1: pw = rate_p_r;
      2'd2: pw = err_d_r;
      default: pw = rate_d_r;
    endcase
    for (int i = 0; i < 7; i++) begin
      raw   = pick9(pw, 3'(i));
      px[i] = m_r[0] ? (signed'({{16{raw[8]}}, raw}) <<< 4) : signed'({{16{raw[8]}}, raw});
    end
    fx = m_r[0] ? signed'({rate_r[23], rate_r}) : signed'({{13{err_r[11]}}, err_r});
    kk = 3'd6;
    for (int k = 5; k >= 1; k--) begin
      if (fx <= px[k]) kk = 3'(k);
    end
    pk      = px[kk];
    pk1     = px[kk - 3'd1];
    num     = pk - fx;
    den     = pk - pk1;
    lo_edge = fx <= px[0];
    hi_edge = fx >= px[6];
  end

  // rule evaluation for the current term
  logic        tg, ta, tb;
  logic [16:0] me, mr, we, wr;
  logic [2:0]  se, sr, idx;
  logic [3:0]  ssum;
  logic [8:0]  pt;
  logic [41:0] acc_nxt;
  always_comb begin
    tg   = term_r[2];
    ta   = term_r[1];
    tb   = term_r[0];
    me   = tg ? mu_r[2] : mu_r[0];
    mr   = tg ? mu_r[3] : mu_r[1];
    se   = tg ? seg_r[2] : seg_r[0];
    sr   = tg ? seg_r[3] : seg_r[1];
    we   = ta ? ONE_MU - me : me;
    wr   = tb ? ONE_MU - mr : mr;
    ssum = 4'(se) + 4'(sr) + 4'(ta) + 4'(tb);
    idx  = (ssum <= 4'd6) ? 3'(4'd6 - ssum) : 3'(ssum - 4'd6);
    if (tg) idx = 3'd6 - idx;
    pt      = pick9(tg ? out_d_r : out_p_r, idx);
    acc_nxt = acc_r + 42'(mul_p);
  end

  // servo sum
  logic signed [TW-1:0] base, tot_n;
  logic [15:0]          servo_n;
  always_comb begin
    base  = (TW'(SERVO_MID) + {{(TW-10){trim_r[9]}}, trim_r}) <<< 20;
    tot_n = tot_r + TW'(prod_r);
    if (tot_n[TW-1]) begin
      servo_n = '0;
    end else if (|tot_n[TW-2:36]) begin
      servo_n = 16'hFFFF;
    end else begin
      servo_n = tot_n[35:20];
    end
  end

  assign mul_p = mul_a * mul_b;

  logic out_load;

  always_comb begin
    state_nxt        = state_r;
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    mul_a            = '0;
    mul_b            = '0;
    out_load         = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_RATE;
      end
      ST_RATE: begin
        if (period_r == '0) begin
          state_nxt = ST_MSEL;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = DIV_W'({abs35, 16'h0});
          div_req.divisor  = period_r;
          state_nxt        = ST_RWAIT;
        end
      end
      ST_RWAIT: begin
        if (div_stat.done) state_nxt = ST_MSEL;
      end
      ST_MSEL: begin
        if (!lo_edge && !hi_edge) begin
          div_req.start    = 1'b1;
          div_req.dividend = {num[12:0], 16'h0};
          div_req.divisor  = den[15:0];
          state_nxt        = ST_MWAIT;
        end else if (m_r == 2'd3) begin
          state_nxt = ST_MULA;
        end
      end
      ST_MWAIT: begin
        if (div_stat.done) state_nxt = (m_r == 2'd3) ? ST_MULA : ST_MSEL;
      end
      ST_MULA: begin
        mul_a     = 34'(we);
        mul_b     = 25'(wr);
        state_nxt = ST_MULB;
      end
      ST_MULB: begin
        mul_a     = prod_r[33:0];
        mul_b     = 25'(pt);
        state_nxt = (term_r == 3'd7) ? ST_SRVA : ST_MULA;
      end
      ST_SRVA: begin
        mul_a     = 34'(kp_r);
        mul_b     = 25'(err_r);
        state_nxt = ST_SRVB;
      end
      ST_SRVB: begin
        mul_a     = 34'(kd_r);
        mul_b     = 25'(rate_r);
        state_nxt = ST_SRVC;
      end
      ST_SRVC: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // configuration and persistent state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_p_r  <= '0;
      rate_p_r <= '0;
      out_p_r  <= '0;
      err_d_r  <= '0;
      rate_d_r <= '0;
      out_d_r  <= '0;
      trim_r   <= '0;
      last_r   <= '0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_ERR_P:  err_p_r  <= cfg_data;
          CFG_RATE_P: rate_p_r <= cfg_data;
          CFG_OUT_P:  out_p_r  <= cfg_data;
          CFG_ERR_D:  err_d_r  <= cfg_data;
          CFG_RATE_D: rate_d_r <= cfg_data;
          CFG_OUT_D:  out_d_r  <= cfg_data;
          CFG_TRIM:   trim_r   <= signed'(cfg_data[9:0]);
          default: ;
        endcase
      end
      if (out_load) last_r <= err_r[9:0];
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        err_r    <= err_n;
        delta_r  <= err_n - last_ext;
        period_r <= in_frame_period;
        m_r      <= '0;
      end
      ST_RATE: begin
        if (period_r == '0) begin
          if (delta_r > 0)      rate_r <= RATE_MAX;
          else if (delta_r < 0) rate_r <= RATE_MIN;
          else                  rate_r <= '0;
        end
      end
      ST_RWAIT: begin
        if (div_stat.done) rate_r <= rate_div[23:0];
      end
      ST_MSEL: begin
        term_r <= '0;
        acc_r  <= '0;
        if (lo_edge) begin
          mu_r[m_r]  <= ONE_MU;
          seg_r[m_r] <= 3'd0;
          m_r        <= m_r + 2'd1;
        end else if (hi_edge) begin
          mu_r[m_r]  <= '0;
          seg_r[m_r] <= 3'd5;
          m_r        <= m_r + 2'd1;
        end else begin
          seg_r[m_r] <= kk - 3'd1;
        end
      end
      ST_MWAIT: begin
        if (div_stat.done) begin
          mu_r[m_r] <= div_quo[16:0];
          m_r       <= m_r + 2'd1;
        end
      end
      ST_MULA: prod_r <= mul_p;
      ST_MULB: begin
        term_r <= term_r + 3'd1;
        if (ta && tb) begin
          acc_r <= '0;
          if (tg) kd_r <= acc_nxt[40:25];
          else    kp_r <= acc_nxt[40:25];
        end else begin
          acc_r <= acc_nxt;
        end
      end
      ST_SRVA: prod_r <= mul_p;
      ST_SRVB: begin
        tot_r  <= base + (TW'(prod_r) <<< 8);
        prod_r <= mul_p;
      end
      ST_SRVC: servo_r <= servo_n;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (out_load) begin
      out_servo_r <= servo_r;
      out_kp_r    <= kp_r;
      out_kd_r    <= kd_r;
      if (err_r > 12'sd255)       out_err_r <= 9'sd255;
      else if (err_r < -12'sd256) out_err_r <= -9'sd256;
      else                        out_err_r <= err_r[8:0];
    end
  end

  fpds_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  assign in_ready       = (state_r == ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_servo_pwm  = out_servo_r;
  assign out_used_error = out_err_r;
  assign out_prop_gain  = out_kp_r;
  assign out_deriv_gain = out_kd_r;

endmodule

/* hdl/fpds_div.sv */
// Restoring divider, one quotient bit per cycle, shared by the steering unit.
// Depends on fpds_pkg.
module fpds_div import fpds_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  div_req_t         req,
  output div_stat_t        stat,
  output logic [DIV_W-1:0] quotient
);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DSR_W-1:0] rem_r, rem_nxt;
  logic [DSR_W-1:0] dsr_r, dsr_nxt;
  logic [DIV_W-1:0] quo_r, quo_nxt;
  logic [DSR_W:0]   rem_sh;
  logic             ge;

  always_comb begin
    rem_sh   = {rem_r, quo_r[DIV_W-1]};
    ge       = rem_sh >= {1'b0, dsr_r};
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    quo_nxt  = quo_r;
    if (req.start) begin
      cnt_nxt  = CNT_W'(DIV_W - 1);
      busy_nxt = 1'b1;
      rem_nxt  = '0;
      dsr_nxt  = req.divisor;
      quo_nxt  = req.dividend;
    end else if (busy_r) begin
      rem_nxt = ge ? DSR_W'(rem_sh - {1'b0, dsr_r}) : rem_sh[DSR_W-1:0];
      quo_nxt = {quo_r[DIV_W-2:0], ge};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    quo_r <= quo_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

/* hdl/fpds_checker.sv */
// Port-level checks of the fuzzy PD steering unit, bound to the top level.
// Depends on fuzzy_pd_steering_unit_defines.svh.
`include "fuzzy_pd_steering_unit_defines.svh"

module fpds_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_servo_pwm,
  input logic [15:0] out_prop_gain,
  input logic [15:0] out_deriv_gain
);

  `FPDS_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
  `FPDS_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_servo_pwm))
  `FPDS_ASSERT_IMP(a_gain_bound, clk, rst_n, out_valid, out_prop_gain <= 16'd65408 && out_deriv_gain <= 16'd65408)
  `FPDS_ASSERT_NXT_ALL(a_reset_clear, clk, !rst_n, !out_valid && in_ready)

endmodule

bind fuzzy_pd_steering_unit fpds_checker u_fpds_checker (.*);
